### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: check failed");

// when ante holds, cons must hold in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

`endif

### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, codes and types of the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int SLOT_COUNT   = 16;
	localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
	localparam int RESULT_LIMIT = 16;
	localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int SEL_W    = 4;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 4;
	localparam int STEP_W   = 16;
	localparam int PEND_W   = 8;
	localparam int ENTRY_W  = 2 * DATA_W + PEND_W;

	localparam int APB_W    = 32;
	localparam int PADDR_W  = 3;

	localparam logic [STEP_W-1:0] TICK_STEP_RST = 16'd10;
	localparam logic [PEND_W-1:0] PEND_MAX      = '1;

	// register index, taken from paddr[2]
	localparam logic REG_TICK_STEP = 1'b0;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_BAD_SLOT   = 2'd2,
		STAT_NONE_READY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SWEEP,
		SEQ_LOOKUP,
		SEQ_RESULT,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [DATA_W-1:0] delay;
		logic [DATA_W-1:0] period;
		logic [PEND_W-1:0] pending;
	} slot_entry_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  slot;
		logic [DATA_W-1:0] delay;
	} result_t;

	// per-slot update decision
	typedef struct packed {
		logic        write;
		slot_entry_t entry;
		logic        emit;
		logic        set_use;
		logic        clr_use;
	} exec_t;

	typedef struct packed {
		logic    push;
		logic    finish;
		result_t push_res;
		result_t fin_res;
	} buf_ctl_t;

	typedef struct packed {
		logic hold_valid;
		logic can_push;
		logic can_finish;
	} buf_stat_t;

	function automatic logic [SLOT_W-1:0] slot_of_sel(input logic [SEL_W-1:0] sel);
		logic [SLOT_W+SEL_W-1:0] wide;
		wide = (SLOT_W + SEL_W)'(sel);
		return wide[SLOT_W-1:0];
	endfunction

	function automatic logic sel_in_range(input logic [SEL_W-1:0] sel);
		return (32'(sel) < 32'(SLOT_COUNT));
	endfunction

	function automatic logic [IDX_W-1:0] idx_of_slot(input logic [SLOT_W-1:0] slot);
		logic [SLOT_W+IDX_W-1:0] wide;
		wide = (SLOT_W + IDX_W)'(slot);
		return wide[IDX_W-1:0];
	endfunction

endpackage

### rtl/periodic_task_slot_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Task slot table in one RAM with a read-modify-write sweep sequencer.
// ----------------------------------------------------------------------------
// Add, tick and dispatch sweep the slot RAM one slot per cycle while results are not
// stalled, and intake stalls until the sweep is done (add stops at the first free
// slot). Delete, read delay and unknown codes step through lookup, result and done.
// The last result is loaded into the output register on the edge that frees intake.
// Reset empties every slot and sets tick_step to 10; the RAM itself is not swept.
`include "assert_macros.svh"

module periodic_task_slot_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pts_pkg::PADDR_W-1:0]   paddr,
	input  logic [pts_pkg::APB_W-1:0]     pwdata,
	output logic [pts_pkg::APB_W-1:0]     prdata,
	output logic                          pready,
	// commands
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [pts_pkg::CMD_W-1:0]     command,
	input  logic [pts_pkg::DATA_W-1:0]    delay_value,
	input  logic [pts_pkg::DATA_W-1:0]    period_value,
	input  logic [pts_pkg::SEL_W-1:0]     slot_select,
	// results
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [pts_pkg::STATUS_W-1:0]  status,
	output logic [pts_pkg::IDX_W-1:0]     slot_index,
	output logic [pts_pkg::DATA_W-1:0]    remaining_delay,
	output logic                          last_of_run
);
	import pts_pkg::*;

	logic [STEP_W-1:0]     tick_step_q;
	seq_state_t            state_q, state_d;
	logic [CMD_W-1:0]      cmd_q;
	logic [DATA_W-1:0]     dval_q;
	logic [DATA_W-1:0]     pval_q;
	logic [SEL_W-1:0]      sel_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  s1_valid_s1;
	logic [SLOT_W-1:0]     s1_idx_s1;
	logic [RES_CNT_W-1:0]  n_q;
	logic [SLOT_COUNT-1:0] in_use_q;

	logic                  cmd_acc;
	logic                  cfg_wr;
	logic                  is_sweep_cmd;
	logic                  rd_more;
	logic                  s1_go;
	logic                  s1_end;
	logic                  adv;
	logic                  sweep_re;
	logic [SLOT_W-1:0]     sel_slot;
	logic                  sel_valid;

	logic                  ram_we;
	logic                  ram_re;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [SLOT_W-1:0]     ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;
	slot_entry_t           rd_entry;

	exec_t                 ex;
	buf_ctl_t              bctl;
	buf_stat_t             bstat;

	// ---------------- configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[PADDR_W-1] == REG_TICK_STEP) ? APB_W'(tick_step_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= TICK_STEP_RST;
		end else if (cfg_wr && paddr[PADDR_W-1] == REG_TICK_STEP) begin
			tick_step_q <= pwdata[STEP_W-1:0];
		end
	end

	// ---------------- command intake
	assign cmd_stall    = (state_q != SEQ_IDLE);
	assign cmd_acc      = cmd_valid && !cmd_stall;
	assign is_sweep_cmd = (command == CMD_ADD) || (command == CMD_TICK) ||
		(command == CMD_DISPATCH);

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q  <= command;
			dval_q <= delay_value;
			pval_q <= period_value;
			sel_q  <= slot_select;
		end
	end

	assign sel_slot  = slot_of_sel(sel_q);
	assign sel_valid = sel_in_range(sel_q) && in_use_q[sel_slot];

	// ---------------- sweep stage 1: RAM data for slot s1_idx is on rdata
	assign rd_entry = slot_entry_t'(ram_rdata);

	pts_slot_exec u_exec (
		.cmd        (cmd_q),
		.in_use     (in_use_q[s1_idx_s1]),
		.entry      (rd_entry),
		.tick_step  (tick_step_q),
		.add_delay  (dval_q),
		.add_period (pval_q),
		.ex         (ex)
	);

	assign rd_more = (rd_cnt_q < CNT_W'(SLOT_COUNT));
	assign s1_go   = (state_q == SEQ_SWEEP) && s1_valid_s1 && (!ex.emit || bstat.can_push);
	assign s1_end  = s1_go && ((s1_idx_s1 == SLOT_W'(SLOT_COUNT - 1)) ||
		(ex.emit && cmd_q == CMD_ADD) ||
		(ex.emit && n_q == RES_CNT_W'(RESULT_LIMIT - 1)));
	assign adv     = !s1_valid_s1 || s1_go;
	// no read while stage 1 waits, so rdata holds its slot
	assign sweep_re = (state_q == SEQ_SWEEP) && adv && rd_more && !s1_end;

	// ---------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (cmd_acc) begin
					state_d = is_sweep_cmd ? SEQ_SWEEP : SEQ_LOOKUP;
				end
			end
			SEQ_SWEEP: begin
				if (s1_end) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_LOOKUP: begin
				state_d = SEQ_RESULT;
			end
			SEQ_RESULT: begin
				state_d = SEQ_DONE;
			end
			SEQ_DONE: begin
				if (bstat.can_finish) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// ---------------- outputs of the sequencer
	always_comb begin
		ram_we    = s1_go && ex.write;
		ram_waddr = s1_idx_s1;
		ram_re    = sweep_re || ((state_q == SEQ_LOOKUP) && sel_in_range(sel_q));
		ram_raddr = (state_q == SEQ_SWEEP) ? rd_cnt_q[SLOT_W-1:0] : sel_slot;

		bctl          = '0;
		bctl.push_res = '{status: STAT_OK, slot: idx_of_slot(s1_idx_s1), delay: '0};
		bctl.fin_res  = '{status: STAT_OK, slot: '0, delay: '0};
		case (state_q)
			SEQ_SWEEP: begin
				bctl.push = s1_go && ex.emit;
			end
			SEQ_RESULT: begin
				bctl.push          = 1'b1;
				bctl.push_res      = '{status: STAT_BAD_SLOT, slot: '0, delay: '0};
				if (sel_valid && cmd_q == CMD_DELETE) begin
					bctl.push_res = '{status: STAT_OK, slot: sel_q, delay: '0};
				end else if (sel_valid && cmd_q == CMD_READ) begin
					bctl.push_res = '{status: STAT_OK, slot: sel_q, delay: rd_entry.delay};
				end
			end
			SEQ_DONE: begin
				bctl.finish = bstat.can_finish;
				case (cmd_q)
					CMD_ADD:      bctl.fin_res.status = STAT_FULL;
					CMD_DISPATCH: bctl.fin_res.status = STAT_NONE_READY;
					default:      bctl.fin_res.status = STAT_OK;
				endcase
			end
			default: begin
			end
		endcase
	end

	// ---------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			rd_cnt_q    <= '0;
			s1_valid_s1 <= 1'b0;
			s1_idx_s1   <= '0;
			n_q         <= '0;
			in_use_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_acc) begin
				rd_cnt_q    <= '0;
				s1_valid_s1 <= 1'b0;
				n_q         <= '0;
			end else if (state_q == SEQ_SWEEP) begin
				if (sweep_re) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (adv) begin
					s1_valid_s1 <= sweep_re;
					s1_idx_s1   <= rd_cnt_q[SLOT_W-1:0];
				end
				if (s1_go && ex.emit) begin
					n_q <= n_q + RES_CNT_W'(1);
				end
			end
			if (s1_go && ex.set_use) begin
				in_use_q[s1_idx_s1] <= 1'b1;
			end else if (s1_go && ex.clr_use) begin
				in_use_q[s1_idx_s1] <= 1'b0;
			end else if (state_q == SEQ_RESULT && cmd_q == CMD_DELETE && sel_valid) begin
				in_use_q[sel_slot] <= 1'b0;
			end
		end
	end

	// ---------------- slot RAM: {delay, period, pending}
	pts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ENTRY_W'(ex.entry)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pts_resp_buf u_resp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (bctl),
		.stat            (bstat),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.slot_index      (slot_index),
		.remaining_delay (remaining_delay),
		.last_of_run     (last_of_run)
	);

	`ASSERT_IMPLY(a_rw_distinct, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`ASSERT_ALWAYS(a_result_limit, clk, arst_n, n_q <= RES_CNT_W'(RESULT_LIMIT))
	`ASSERT_IMPLY(a_idle_hold_empty, clk, arst_n, state_q == SEQ_IDLE, !bstat.hold_valid)

endmodule

### rtl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pts_slot_exec.sv
// ----------------------------------------------------------------------------
// pts_slot_exec
// Update of one slot during an add, tick or dispatch sweep.
// ----------------------------------------------------------------------------
module pts_slot_exec (
	input  logic [pts_pkg::CMD_W-1:0]  cmd,
	input  logic                       in_use,
	input  pts_pkg::slot_entry_t       entry,
	input  logic [pts_pkg::STEP_W-1:0] tick_step,
	input  logic [pts_pkg::DATA_W-1:0] add_delay,
	input  logic [pts_pkg::DATA_W-1:0] add_period,
	output pts_pkg::exec_t             ex
);
	import pts_pkg::*;

	logic [DATA_W-1:0] aged;
	logic              fire;

	always_comb begin
		ex       = '0;
		ex.entry = entry;
		aged     = entry.delay;
		fire     = 1'b0;
		case (cmd)
			CMD_ADD: begin
				if (!in_use) begin
					ex.write         = 1'b1;
					ex.entry.delay   = add_delay;
					ex.entry.period  = add_period;
					ex.entry.pending = '0;
					ex.emit          = 1'b1;
					ex.set_use       = 1'b1;
				end
			end
			CMD_TICK: begin
				if (in_use) begin
					if (entry.delay != '0) begin
						// saturating subtract
						aged = (entry.delay > DATA_W'(tick_step)) ?
							entry.delay - DATA_W'(tick_step) : '0;
						fire = (aged == '0);
					end else begin
						fire = 1'b1;
					end
					ex.write       = 1'b1;
					ex.entry.delay = aged;
					if (fire) begin
						if (entry.pending != PEND_MAX) begin
							ex.entry.pending = entry.pending + PEND_W'(1);
						end
						if (entry.period != '0) begin
							ex.entry.delay = entry.period;
						end
					end
				end
			end
			CMD_DISPATCH: begin
				if (in_use && entry.pending != '0) begin
					ex.write         = 1'b1;
					ex.entry.pending = entry.pending - PEND_W'(1);
					ex.emit          = 1'b1;
					ex.clr_use       = (entry.period == '0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/pts_resp_buf.sv
// ----------------------------------------------------------------------------
// pts_resp_buf
// Result holding stage plus output register; marks the last result of a run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_resp_buf (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pts_pkg::buf_ctl_t            ctl,
	output pts_pkg::buf_stat_t           stat,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [pts_pkg::STATUS_W-1:0] status,
	output logic [pts_pkg::IDX_W-1:0]    slot_index,
	output logic [pts_pkg::DATA_W-1:0]   remaining_delay,
	output logic                         last_of_run
);
	import pts_pkg::*;

	result_t hold_q;
	logic    hold_valid_q;
	result_t out_q;
	logic    out_last_q;
	logic    out_valid_q;

	logic    out_free;
	logic    out_load;
	result_t out_d;
	logic    out_last_d;

	assign out_free = !out_valid_q || !rsp_stall;

	// a result is held back until the next one (or the end) decides its last mark
	always_comb begin
		out_load   = 1'b0;
		out_d      = hold_q;
		out_last_d = 1'b0;
		if (ctl.finish) begin
			out_load   = 1'b1;
			out_d      = hold_valid_q ? hold_q : ctl.fin_res;
			out_last_d = 1'b1;
		end else if (ctl.push && hold_valid_q) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.finish) begin
				hold_valid_q <= 1'b0;
			end else if (ctl.push) begin
				hold_valid_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			hold_q <= ctl.push_res;
		end
		if (out_load) begin
			out_q      <= out_d;
			out_last_q <= out_last_d;
		end
	end

	assign stat.hold_valid = hold_valid_q;
	assign stat.can_push   = !hold_valid_q || out_free;
	assign stat.can_finish = out_free;

	assign rsp_valid       = out_valid_q;
	assign status          = out_q.status;
	assign slot_index      = out_q.slot;
	assign remaining_delay = out_q.delay;
	assign last_of_run     = out_last_q;

	`ASSERT_ALWAYS(a_push_finish_excl, clk, arst_n, !(ctl.push && ctl.finish))
	`ASSERT_IMPLY(a_spill_needs_room, clk, arst_n, ctl.push && hold_valid_q, out_free)
	`ASSERT_IMPLY(a_finish_needs_room, clk, arst_n, ctl.finish, out_free)

endmodule

### tb/tb_periodic_task_slot_scheduler.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_slot_scheduler
// Self-checking bench for the periodic task slot scheduler. A class keeps a
// shadow copy of the slot table and tick step. It works out every response
// of each accepted command and compares the responses the block returns, in
// order. A directed opening covers the corner cases. Random phases follow
// with several tick steps and idle/stall mixes, then a long tick run that
// drives the pending counts to saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_periodic_task_slot_scheduler;
	import pts_pkg::*;

	localparam logic [CMD_W-1:0]   CMD_FIRST_UNUSED = CMD_READ + 3'd1;
	localparam logic [CMD_W-1:0]   CMD_LAST_UNUSED  = '1;
	localparam logic [PADDR_W-1:0] TICK_STEP_ADDR   = {REG_TICK_STEP, 2'b00};
	localparam int                 DRAIN_CYCLES     = SLOT_COUNT + 8;
	localparam int                 MAX_SHOWN        = 10;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  slot;
		logic [DATA_W-1:0] delay;
		logic              last;
	} sched_rsp_t;

	class slot_table_scoreboard;
		bit                in_use[SLOT_COUNT];
		logic [DATA_W-1:0] delay[SLOT_COUNT];
		logic [DATA_W-1:0] period[SLOT_COUNT];
		logic [PEND_W-1:0] runs[SLOT_COUNT];
		logic [STEP_W-1:0] step;
		sched_rsp_t        due_results[$];
		int                mismatches;

		function new();
			for (int i = 0; i < SLOT_COUNT; i++) free_slot(i);
			step = TICK_STEP_RST;
			mismatches = 0;
		endfunction

		function void free_slot(int i);
			in_use[i] = 1'b0;
			delay[i]  = '0;
			period[i] = '0;
			runs[i]   = '0;
		endfunction

		function void fire(int i);
			if (runs[i] != PEND_MAX) runs[i]++;
			if (period[i] != '0) delay[i] = period[i];
		endfunction

		function void queue_result(status_t s, int slot, logic [DATA_W-1:0] d, bit last);
			sched_rsp_t r;
			r.status = s;
			r.slot   = IDX_W'(slot);
			r.delay  = d;
			r.last   = last;
			due_results.push_back(r);
		endfunction

		// apply one accepted command to the shadow table
		function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] dval,
				logic [DATA_W-1:0] pval, logic [SEL_W-1:0] sel);
			int free_idx;
			int ready;
			int emit_cnt;
			int n;
			free_idx = -1;
			ready = 0;
			n = 0;
			case (cmd)
				CMD_ADD: begin
					for (int i = SLOT_COUNT - 1; i >= 0; i--)
						if (!in_use[i]) free_idx = i;
					if (free_idx < 0) begin
						queue_result(STAT_FULL, 0, '0, 1'b1);
					end else begin
						in_use[free_idx] = 1'b1;
						delay[free_idx]  = dval;
						period[free_idx] = pval;
						runs[free_idx]   = '0;
						queue_result(STAT_OK, free_idx, '0, 1'b1);
					end
				end
				CMD_DELETE: begin
					if (in_use[sel]) begin
						free_slot(sel);
						queue_result(STAT_OK, sel, '0, 1'b1);
					end else begin
						queue_result(STAT_BAD_SLOT, 0, '0, 1'b1);
					end
				end
				CMD_TICK: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (in_use[i]) begin
							if (delay[i] != '0) begin
								delay[i] = (delay[i] > DATA_W'(step)) ?
									delay[i] - DATA_W'(step) : '0;
								if (delay[i] == '0) fire(i);
							end else begin
								fire(i);
							end
						end
					end
					queue_result(STAT_OK, 0, '0, 1'b1);
				end
				CMD_DISPATCH: begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (in_use[i] && runs[i] != '0) ready++;
					emit_cnt = (ready < RESULT_LIMIT) ? ready : RESULT_LIMIT;
					for (int i = 0; i < SLOT_COUNT && n < RESULT_LIMIT; i++) begin
						if (in_use[i] && runs[i] != '0) begin
							queue_result(STAT_OK, i, '0, n == emit_cnt - 1);
							n++;
							runs[i]--;
							if (period[i] == '0) free_slot(i);
						end
					end
					if (n == 0) queue_result(STAT_NONE_READY, 0, '0, 1'b1);
				end
				CMD_READ: begin
					if (in_use[sel]) queue_result(STAT_OK, sel, delay[sel], 1'b1);
					else queue_result(STAT_BAD_SLOT, 0, '0, 1'b1);
				end
				default: begin
					queue_result(STAT_BAD_SLOT, 0, '0, 1'b1);
				end
			endcase
		endfunction

		function void check_result(sched_rsp_t got);
			sched_rsp_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("stray response: status %0d slot %0d delay %h last %b",
						got.status, got.slot, got.delay, got.last);
				return;
			end
			want = due_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display({"mismatch: exp status %0d slot %0d delay %h last %b,",
						" got status %0d slot %0d delay %h last %b"},
						want.status, want.slot, want.delay, want.last,
						got.status, got.slot, got.delay, got.last);
			end
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n          = 1'b0;
	logic                psel            = 1'b0;
	logic                penable         = 1'b0;
	logic                pwrite          = 1'b0;
	logic [PADDR_W-1:0]  paddr           = '0;
	logic [APB_W-1:0]    pwdata          = '0;
	logic [APB_W-1:0]    prdata;
	logic                pready;
	logic                cmd_valid       = 1'b0;
	logic                cmd_stall;
	logic [CMD_W-1:0]    command         = '0;
	logic [DATA_W-1:0]   delay_value     = '0;
	logic [DATA_W-1:0]   period_value    = '0;
	logic [SEL_W-1:0]    slot_select     = '0;
	logic                rsp_valid;
	logic                rsp_stall       = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    slot_index;
	logic [DATA_W-1:0]   remaining_delay;
	logic                last_of_run;

	slot_table_scoreboard sb;
	sched_rsp_t           seen_rsp;
	int                   send_idle_pct = 0;
	int                   rsp_stall_pct = 0;

	periodic_task_slot_scheduler dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("periodic_task_slot_scheduler test failed");
		$finish;
	end

	// response side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen_rsp.status = status_t'(status);
			seen_rsp.slot   = slot_index;
			seen_rsp.delay  = remaining_delay;
			seen_rsp.last   = last_of_run;
			sb.check_result(seen_rsp);
		end
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] dval,
			logic [DATA_W-1:0] pval, logic [SEL_W-1:0] sel);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid    <= 1'b1;
		command      <= cmd;
		delay_value  <= dval;
		period_value <= pval;
		slot_select  <= sel;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_command(cmd, dval, pval, sel);
	endtask

	// hold commands until every response is back, then let the sweep settle
	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// optional write, always followed by a read-back
	task automatic tick_step_access(bit wr, logic [STEP_W-1:0] val);
		logic [APB_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		paddr   <= TICK_STEP_ADDR;
		pwdata  <= APB_W'(val);
		pwrite  <= wr;
		if (wr) begin
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			penable <= 1'b0;
			pwrite  <= 1'b0;
			sb.step = val;
		end
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[STEP_W-1:0] !== sb.step) begin
			sb.mismatches++;
			if (sb.mismatches <= MAX_SHOWN)
				$display("tick_step read-back: exp %h got %h", sb.step, rd[STEP_W-1:0]);
		end
	endtask

	// mostly short times so tasks actually fire; full-width values now and then
	function automatic logic [DATA_W-1:0] pick_time(int zero_pct);
		int r;
		r = $urandom_range(99);
		if (r < zero_pct) return '0;
		if (r < 65) return DATA_W'($urandom_range(60));
		if (r < 85) return DATA_W'($urandom_range(2000));
		return DATA_W'($urandom);
	endfunction

	function automatic logic [SEL_W-1:0] pick_slot();
		int s;
		s = $urandom_range(SLOT_COUNT - 1);
		if ($urandom_range(1) == 1)
			for (int k = 0; k < SLOT_COUNT && !sb.in_use[s]; k++) s = (s + 1) % SLOT_COUNT;
		return SEL_W'(s);
	endfunction

	task automatic send_random();
		int r;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(99);
		if (r < 25) cmd = CMD_ADD;
		else if (r < 37) cmd = CMD_DELETE;
		else if (r < 65) cmd = CMD_TICK;
		else if (r < 84) cmd = CMD_DISPATCH;
		else if (r < 97) cmd = CMD_READ;
		else cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
		send_cmd(cmd, pick_time(10), pick_time(30), pick_slot());
	endtask

	task automatic run_phase(logic [STEP_W-1:0] step, int send_pct, int stall_pct,
			int items, int pause_every);
		drain();
		tick_step_access(1'b1, step);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
		for (int n = 0; n < items; n++) begin
			if (pause_every > 0 && n > 0 && n % pause_every == 0) drain();
			send_random();
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tick_step_access(1'b0, '0);

		// directed opening at the reset tick step
		send_cmd(CMD_DISPATCH, '0, '0, '0);
		send_cmd(CMD_TICK, '1, '1, '1);
		send_cmd(CMD_READ, '0, '0, 4'd15);
		send_cmd(CMD_DELETE, '0, '0, '0);
		send_cmd(CMD_LAST_UNUSED, '1, '1, '1);
		send_cmd(CMD_ADD, '0, '0, '0);             // one-shot already due
		send_cmd(CMD_ADD, '1, '1, '0);
		send_cmd(CMD_ADD, 32'd5, 32'd7, '0);       // step overshoots, clamps at zero
		send_cmd(CMD_ADD, 32'd10, '0, '0);         // lands exactly on zero
		send_cmd(CMD_READ, '0, '0, 4'd1);
		send_cmd(CMD_TICK, '0, '0, '0);
		send_cmd(CMD_TICK, '0, '0, '0);
		send_cmd(CMD_READ, '0, '0, 4'd2);
		send_cmd(CMD_DISPATCH, '0, '0, '0);
		send_cmd(CMD_DISPATCH, '0, '0, '0);
		send_cmd(CMD_DELETE, '0, '0, 4'd1);
		send_cmd(CMD_READ, '0, '0, 4'd1);
		send_cmd(CMD_FIRST_UNUSED, '0, '0, '0);
		// fill up; the last add finds no free slot
		for (int i = 0; i < SLOT_COUNT; i++)
			send_cmd(CMD_ADD, {DATA_W{i[0]}}, {DATA_W{~i[0]}}, '0);

		run_phase(TICK_STEP_RST, 0, 0, 20, 0);
		run_phase(16'd1, 52, 0, 20, 0);
		run_phase('1, 0, 52, 20, 0);
		run_phase('0, 14, 14, 15, 0);
		run_phase(STEP_W'($urandom_range(2, 40)), 0, 0, 20, 8);

		// every slot fires on every tick until the pending counts saturate
		drain();
		tick_step_access(1'b1, '1);
		send_idle_pct = 14;
		rsp_stall_pct = 14;
		for (int i = 0; i < SLOT_COUNT; i++) send_cmd(CMD_DELETE, '0, '0, SEL_W'(i));
		for (int i = 0; i < SLOT_COUNT; i++) send_cmd(CMD_ADD, '0, DATA_W'(i + 1), '0);
		repeat (int'(PEND_MAX) + 5)
			send_cmd(CMD_TICK, $urandom, $urandom, SEL_W'($urandom_range(15)));
		repeat (3) send_cmd(CMD_DISPATCH, '0, '0, '0);
		send_cmd(CMD_READ, '0, '0, 4'd15);

		drain();
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("periodic_task_slot_scheduler test passed");
		else
			$display("periodic_task_slot_scheduler test failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/pts_slot_exec.sv
rtl/pts_resp_buf.sv
rtl/periodic_task_slot_scheduler.sv
tb/tb_periodic_task_slot_scheduler.sv
